FILE: hdl/double_density_pair_force_core_assert.svh
// Assertion macros for the double-density pair force core.
`ifndef DOUBLE_DENSITY_PAIR_FORCE_CORE_ASSERT_SVH
`define DOUBLE_DENSITY_PAIR_FORCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DDPF_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define DDPF_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define DDPF_ASSERT_IMPL(label, clk, rst_n, prop)
`define DDPF_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: hdl/ddpf_pkg.sv
// Shared constants, types and arithmetic helpers for the pair force core.
`default_nettype none
package ddpf_pkg;
    localparam int DataW = 32;
    localparam int LenW = 31;
    localparam int SqW = 65;
    localparam int RootW = 33;
    localparam int QuoW = 48;
    localparam int DivW = 49;
    localparam int RootStages = 33;
    localparam int DivStages = 49;

    localparam logic [1:0] RegLengthScale = 2'd0;
    localparam logic [1:0] RegPressureGain = 2'd1;
    localparam logic [1:0] RegDampingGain = 2'd2;

    typedef logic signed [DataW-1:0] q16_t;

    function automatic q16_t sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (v < -66'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Q16.16 multiply: arithmetic shift floors toward minus infinity
    function automatic q16_t qmul(input q16_t a, input q16_t b);
        logic signed [63:0] p;
        p = a * b;
        return sat32(66'(p >>> 16));
    endfunction
endpackage
`default_nettype wire

FILE: hdl/ddpf_sqrt_stage.sv
// One restoring square-root step on a 66-bit radicand.
`default_nettype none
module ddpf_sqrt_stage (
    input  wire logic [65:0] rem_i,
    input  wire logic [65:0] root_i,
    input  wire logic [65:0] bit_i,
    output logic      [65:0] rem_o,
    output logic      [65:0] root_o
);
    import ddpf_pkg::*;
    always_comb
    begin
        if (rem_i >= root_i + bit_i)
        begin
            rem_o = rem_i - (root_i + bit_i);
            root_o = (root_i >> 1) + bit_i;
        end
        else
        begin
            rem_o = rem_i;
            root_o = root_i >> 1;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/double_density_pair_force_core.sv
// Pair force core: pipelined sqrt, division and multiply chain.
// Stages in order: squares and averages, sum, square root, divisions, alignment pad, multiply chain.
// Throughput: one beat per cycle; the whole pipeline advances when the output
// register is empty or taken, so a stall holds every stage in place.
// Square root and both divisions are one bit per stage; multiplies at most one level per stage.
// Reset (rst_n low, asynchronous) clears all valid bits and loads register defaults.
`default_nettype none
module double_density_pair_force_core (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire ddpf_pkg::q16_t pos_dx,
    input  wire ddpf_pkg::q16_t pos_dy,
    input  wire ddpf_pkg::q16_t pos_dz,
    input  wire ddpf_pkg::q16_t vel_dx,
    input  wire ddpf_pkg::q16_t vel_dy,
    input  wire ddpf_pkg::q16_t vel_dz,
    input  wire ddpf_pkg::q16_t near_density_first,
    input  wire ddpf_pkg::q16_t near_density_second,
    input  wire ddpf_pkg::q16_t far_density_first,
    input  wire ddpf_pkg::q16_t far_density_second,
    output logic out_valid,
    input  wire logic out_ready,
    output ddpf_pkg::q16_t force_x,
    output ddpf_pkg::q16_t force_y,
    output ddpf_pkg::q16_t force_z
);
    import ddpf_pkg::*;
`include "double_density_pair_force_core_assert.svh"

    typedef struct packed {
        q16_t px, py, pz, vx, vy, vz, na, fa;
    } ctx_t;

    localparam int NSt = 2 + RootStages + DivStages + DivStages + 6;

    logic [LenW-1:0] length_scale_reg;
    q16_t pressure_gain_reg, damping_gain_reg;
    logic adv;
    logic [NSt-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_scale_reg <= LenW'(65536);
            pressure_gain_reg <= 32'sd65536;
            damping_gain_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegLengthScale: length_scale_reg <= cfg_data[LenW-1:0];
                RegPressureGain: pressure_gain_reg <= cfg_data;
                RegDampingGain: damping_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign adv = !v_reg[NSt-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = v_reg[NSt-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NSt-2:0], in_valid};
    end

    // stage 0: squares and averages
    ctx_t c0_reg;
    logic [63:0] sqx_reg, sqy_reg, sqz_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg.px <= pos_dx; c0_reg.py <= pos_dy; c0_reg.pz <= pos_dz;
            c0_reg.vx <= vel_dx; c0_reg.vy <= vel_dy; c0_reg.vz <= vel_dz;
            c0_reg.na <= 32'(($signed({near_density_first[31], near_density_first})
                + $signed({near_density_second[31], near_density_second})) >>> 1);
            c0_reg.fa <= 32'(($signed({far_density_first[31], far_density_first})
                + $signed({far_density_second[31], far_density_second})) >>> 1);
            sqx_reg <= 64'(pos_dx) * 64'(pos_dx);
            sqy_reg <= 64'(pos_dy) * 64'(pos_dy);
            sqz_reg <= 64'(pos_dz) * 64'(pos_dz);
        end
    end

    // stage 1: sum
    ctx_t c1_reg;
    logic [65:0] s_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg <= c0_reg;
            s_reg <= 66'(sqx_reg) + 66'(sqy_reg) + 66'(sqz_reg) + 66'd1;
        end
    end

    // square root, one result bit per stage
    ctx_t rc_reg [RootStages+1];
    logic [65:0] rr_reg [RootStages+1];
    logic [65:0] rq_reg [RootStages+1];
    always_comb
    begin
        rc_reg[0] = c1_reg;
        rr_reg[0] = s_reg;
        rq_reg[0] = '0;
    end
    for (genvar g = 0; g < RootStages; g++)
    begin : g_root
        logic [65:0] rem_w, root_w;
        ddpf_sqrt_stage u_st (
            .rem_i(rr_reg[g]), .root_i(rq_reg[g]),
            .bit_i(66'd1 << (64 - 2*g)),
            .rem_o(rem_w), .root_o(root_w)
        );
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rc_reg[g+1] <= rc_reg[g];
                rr_reg[g+1] <= rem_w;
                rq_reg[g+1] <= root_w;
            end
        end
    end

    logic [RootW-1:0] d_w;
    assign d_w = (rq_reg[RootStages][RootW-1:0] == '0) ? RootW'(1)
                                                          : rq_reg[RootStages][RootW-1:0];

    // divisions: d<<16 / ls and |rp|<<16 / d (three lanes), restoring
    typedef struct packed {
        logic [DivW-1:0] r0, r1, r2, r3;
        logic [DivW-1:0] n0, n1, n2, n3;
    } div_t;
    ctx_t dc_reg [DivStages+1];
    div_t dv_reg [DivStages+1];
    logic [RootW-1:0] dd_reg [DivStages+1];
    logic [LenW-1:0] dl_reg [DivStages+1];
    logic [2:0] dsg_reg [DivStages+1];
    always_comb
    begin
        dc_reg[0] = rc_reg[RootStages];
        dd_reg[0] = d_w;
        dl_reg[0] = (length_scale_reg == '0) ? LenW'(1) : length_scale_reg;
        dsg_reg[0] = {rc_reg[RootStages].pz[31], rc_reg[RootStages].py[31],
                      rc_reg[RootStages].px[31]};
        dv_reg[0].r0 = '0; dv_reg[0].r1 = '0; dv_reg[0].r2 = '0; dv_reg[0].r3 = '0;
        dv_reg[0].n0 = DivW'(d_w) << 16;
        dv_reg[0].n1 = DivW'(rc_reg[RootStages].px[31] ? -33'(rc_reg[RootStages].px)
                                                        : 33'(rc_reg[RootStages].px)) << 16;
        dv_reg[0].n2 = DivW'(rc_reg[RootStages].py[31] ? -33'(rc_reg[RootStages].py)
                                                        : 33'(rc_reg[RootStages].py)) << 16;
        dv_reg[0].n3 = DivW'(rc_reg[RootStages].pz[31] ? -33'(rc_reg[RootStages].pz)
                                                        : 33'(rc_reg[RootStages].pz)) << 16;
    end
    for (genvar g = 0; g < DivStages; g++)
    begin : g_div
        div_t nx;
        logic [DivW:0] t0, t1, t2, t3;
        always_comb
        begin
            t0 = {dv_reg[g].r0, dv_reg[g].n0[DivW-1]};
            t1 = {dv_reg[g].r1, dv_reg[g].n1[DivW-1]};
            t2 = {dv_reg[g].r2, dv_reg[g].n2[DivW-1]};
            t3 = {dv_reg[g].r3, dv_reg[g].n3[DivW-1]};
            nx = dv_reg[g];
            if (t0 >= (DivW+1)'(dl_reg[g]))
            begin
                nx.r0 = DivW'(t0 - (DivW+1)'(dl_reg[g]));
                nx.n0 = {dv_reg[g].n0[DivW-2:0], 1'b1};
            end
            else
            begin
                nx.r0 = DivW'(t0);
                nx.n0 = {dv_reg[g].n0[DivW-2:0], 1'b0};
            end
            if (t1 >= (DivW+1)'(dd_reg[g]))
            begin
                nx.r1 = DivW'(t1 - (DivW+1)'(dd_reg[g]));
                nx.n1 = {dv_reg[g].n1[DivW-2:0], 1'b1};
            end
            else
            begin
                nx.r1 = DivW'(t1);
                nx.n1 = {dv_reg[g].n1[DivW-2:0], 1'b0};
            end
            if (t2 >= (DivW+1)'(dd_reg[g]))
            begin
                nx.r2 = DivW'(t2 - (DivW+1)'(dd_reg[g]));
                nx.n2 = {dv_reg[g].n2[DivW-2:0], 1'b1};
            end
            else
            begin
                nx.r2 = DivW'(t2);
                nx.n2 = {dv_reg[g].n2[DivW-2:0], 1'b0};
            end
            if (t3 >= (DivW+1)'(dd_reg[g]))
            begin
                nx.r3 = DivW'(t3 - (DivW+1)'(dd_reg[g]));
                nx.n3 = {dv_reg[g].n3[DivW-2:0], 1'b1};
            end
            else
            begin
                nx.r3 = DivW'(t3);
                nx.n3 = {dv_reg[g].n3[DivW-2:0], 1'b0};
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dc_reg[g+1] <= dc_reg[g];
                dv_reg[g+1] <= nx;
                dd_reg[g+1] <= dd_reg[g];
                dl_reg[g+1] <= dl_reg[g];
                dsg_reg[g+1] <= dsg_reg[g];
            end
        end
    end

    // quotients: ratio in n0, normal magnitudes in n1..n3
    ctx_t e_c;
    logic signed [65:0] q_full;
    q16_t nx_w, ny_w, nz_w;
    always_comb
    begin
        e_c = dc_reg[DivStages];
        q_full = 66'sd65536 - $signed({17'd0, dv_reg[DivStages].n0});
        nx_w = dsg_reg[DivStages][0] ? -32'(dv_reg[DivStages].n1) : 32'(dv_reg[DivStages].n1);
        ny_w = dsg_reg[DivStages][1] ? -32'(dv_reg[DivStages].n2) : 32'(dv_reg[DivStages].n2);
        nz_w = dsg_reg[DivStages][2] ? -32'(dv_reg[DivStages].n3) : 32'(dv_reg[DivStages].n3);
    end

    // delay alignment: the divider already took DivStages; pad with one more
    // block of DivStages so the total matches NSt
    ctx_t pc_reg [DivStages+1];
    q16_t pq_reg [DivStages+1];
    q16_t pnx_reg [DivStages+1], pny_reg [DivStages+1], pnz_reg [DivStages+1];
    always_comb
    begin
        pc_reg[0] = e_c;
        pq_reg[0] = sat32(q_full);
        pnx_reg[0] = nx_w; pny_reg[0] = ny_w; pnz_reg[0] = nz_w;
    end
    for (genvar g = 0; g < DivStages; g++)
    begin : g_pad
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pc_reg[g+1] <= pc_reg[g];
                pq_reg[g+1] <= pq_reg[g];
                pnx_reg[g+1] <= pnx_reg[g];
                pny_reg[g+1] <= pny_reg[g];
                pnz_reg[g+1] <= pnz_reg[g];
            end
        end
    end

    // multiply chain, at most one multiply level per stage
    q16_t q1_reg, nq1_reg, fq1_reg;
    q16_t nxa_reg, nya_reg, nza_reg, dx1_reg, dy1_reg, dz1_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_reg <= pq_reg[DivStages];
            nq1_reg <= qmul(pc_reg[DivStages].na, pq_reg[DivStages]);
            fq1_reg <= qmul(pc_reg[DivStages].fa, pq_reg[DivStages]);
            dx1_reg <= qmul(pc_reg[DivStages].vx, pq_reg[DivStages]);
            dy1_reg <= qmul(pc_reg[DivStages].vy, pq_reg[DivStages]);
            dz1_reg <= qmul(pc_reg[DivStages].vz, pq_reg[DivStages]);
            nxa_reg <= pnx_reg[DivStages];
            nya_reg <= pny_reg[DivStages];
            nza_reg <= pnz_reg[DivStages];
        end
    end

    q16_t nq2_reg, ffq2_reg, nxb_reg, nyb_reg, nzb_reg, dx2_reg, dy2_reg, dz2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nq2_reg <= nq1_reg;
            ffq2_reg <= qmul(fq1_reg, q1_reg);
            nxb_reg <= nxa_reg; nyb_reg <= nya_reg; nzb_reg <= nza_reg;
            dx2_reg <= qmul(dx1_reg, damping_gain_reg);
            dy2_reg <= qmul(dy1_reg, damping_gain_reg);
            dz2_reg <= qmul(dz1_reg, damping_gain_reg);
        end
    end

    q16_t pres3_reg, nxc_reg, nyc_reg, nzc_reg, dx3_reg, dy3_reg, dz3_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pres3_reg <= sat32(66'(nq2_reg) + 66'(ffq2_reg));
            nxc_reg <= nxb_reg; nyc_reg <= nyb_reg; nzc_reg <= nzb_reg;
            dx3_reg <= dx2_reg; dy3_reg <= dy2_reg; dz3_reg <= dz2_reg;
        end
    end

    q16_t px4_reg, py4_reg, pz4_reg, dx4_reg, dy4_reg, dz4_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px4_reg <= qmul(nxc_reg, pres3_reg);
            py4_reg <= qmul(nyc_reg, pres3_reg);
            pz4_reg <= qmul(nzc_reg, pres3_reg);
            dx4_reg <= dx3_reg; dy4_reg <= dy3_reg; dz4_reg <= dz3_reg;
        end
    end

    q16_t px5_reg, py5_reg, pz5_reg, dx5_reg, dy5_reg, dz5_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px5_reg <= qmul(px4_reg, pressure_gain_reg);
            py5_reg <= qmul(py4_reg, pressure_gain_reg);
            pz5_reg <= qmul(pz4_reg, pressure_gain_reg);
            dx5_reg <= dx4_reg; dy5_reg <= dy4_reg; dz5_reg <= dz4_reg;
        end
    end

    q16_t fx_reg, fy_reg, fz_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fx_reg <= sat32(66'(px5_reg) - 66'(dx5_reg));
            fy_reg <= sat32(66'(py5_reg) - 66'(dy5_reg));
            fz_reg <= sat32(66'(pz5_reg) - 66'(dz5_reg));
        end
    end

    assign force_x = fx_reg;
    assign force_y = fy_reg;
    assign force_z = fz_reg;

    `DDPF_ASSERT_IMPL(a_stall_holds, clk, rst_n,
        (out_valid && !out_ready) |=> (out_valid && $stable(force_x)))
    `DDPF_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready)
    `DDPF_ASSERT_NEVER(a_no_stall_ready, clk, rst_n, out_valid && !out_ready && in_ready)
endmodule
`default_nettype wire

FILE: tb/tb_double_density_pair_force_core.sv
// Testbench for the double-density pair force core: directed and random pair stimulus, scoreboard check.
`timescale 1ns / 100ps
`default_nettype none

class pair_force_board;
    logic [30:0] length_scale;
    ddpf_pkg::q16_t pressure_gain;
    ddpf_pkg::q16_t damping_gain;
    ddpf_pkg::q16_t fx_q[$];
    ddpf_pkg::q16_t fy_q[$];
    ddpf_pkg::q16_t fz_q[$];
    int errors;

    function new();
        length_scale = 31'd65536;
        pressure_gain = 32'sd65536;
        damping_gain = 32'sd0;
        errors = 0;
    endfunction

    function automatic ddpf_pkg::q16_t clip(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic ddpf_pkg::q16_t fx_mul(input ddpf_pkg::q16_t a, input ddpf_pkg::q16_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return clip(p >>> 16);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [64:0] x);
        logic [65:0] rem;
        logic [65:0] res;
        logic [65:0] bt;
        rem = {1'b0, x};
        res = 0;
        bt = 66'd1 << 64;
        while (bt > rem)
        begin
            bt = bt >> 2;
        end
        while (bt != 0)
        begin
            if (rem >= res + bt)
            begin
                rem = rem - (res + bt);
                res = (res >> 1) + bt;
            end
            else
            begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res[63:0];
    endfunction

    function void note_pair(input ddpf_pkg::q16_t rp[3], input ddpf_pkg::q16_t rv[3],
                            input ddpf_pkg::q16_t nf, input ddpf_pkg::q16_t ns,
                            input ddpf_pkg::q16_t ff, input ddpf_pkg::q16_t fs);
        logic [64:0] sq;
        logic [63:0] root_len;
        logic [95:0] ratio;
        longint ls;
        longint nf_avg;
        longint ff_avg;
        ddpf_pkg::q16_t q;
        ddpf_pkg::q16_t pres;
        ddpf_pkg::q16_t nrm;
        ddpf_pkg::q16_t push;
        ddpf_pkg::q16_t drag;
        ddpf_pkg::q16_t f[3];
        sq = 65'd1;
        for (int i = 0; i < 3; i++)
        begin
            sq = sq + 65'(64'(longint'(rp[i]) * longint'(rp[i])));
        end
        root_len = int_sqrt(sq);
        if (root_len == 0)
        begin
            root_len = 64'd1;
        end
        ls = (length_scale == 0) ? 1 : longint'(length_scale);
        ratio = ({32'd0, root_len} << 16) / 96'(ls);
        if (ratio > 96'd65536 + 96'd2147483648)
        begin
            q = 32'sh80000000;
        end
        else
        begin
            q = clip(65536 - longint'(ratio[63:0]));
        end
        nf_avg = (longint'(nf) + longint'(ns)) >>> 1;
        ff_avg = (longint'(ff) + longint'(fs)) >>> 1;
        pres = clip(longint'(fx_mul(nf_avg[31:0], q))
                    + longint'(fx_mul(fx_mul(ff_avg[31:0], q), q)));
        for (int i = 0; i < 3; i++)
        begin
            nrm = 32'((longint'(rp[i]) * 65536) / longint'(root_len));
            push = fx_mul(fx_mul(nrm, pres), pressure_gain);
            drag = fx_mul(fx_mul(rv[i], q), damping_gain);
            f[i] = clip(longint'(push) - longint'(drag));
        end
        fx_q.push_back(f[0]);
        fy_q.push_back(f[1]);
        fz_q.push_back(f[2]);
    endfunction

    function void check_force(input ddpf_pkg::q16_t ax, input ddpf_pkg::q16_t ay,
                              input ddpf_pkg::q16_t az);
        ddpf_pkg::q16_t ex;
        ddpf_pkg::q16_t ey;
        ddpf_pkg::q16_t ez;
        if (fx_q.size() == 0)
        begin
            $display("%0t unexpected force beat %0d %0d %0d", $time, ax, ay, az);
            errors++;
            return;
        end
        ex = fx_q.pop_front();
        ey = fy_q.pop_front();
        ez = fz_q.pop_front();
        if (ax !== ex)
        begin
            $display("%0t force_x expected %0d actual %0d", $time, ex, ax);
            errors++;
        end
        if (ay !== ey)
        begin
            $display("%0t force_y expected %0d actual %0d", $time, ey, ay);
            errors++;
        end
        if (az !== ez)
        begin
            $display("%0t force_z expected %0d actual %0d", $time, ez, az);
            errors++;
        end
    endfunction
endclass

module tb_double_density_pair_force_core;
    import ddpf_pkg::*;

    localparam int Latency = 139;
    localparam longint CycleLimit = 2000000;
    // index past the last register: the write must be ignored
    localparam logic [1:0] RegSpare = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_ready;
    q16_t pos_dx, pos_dy, pos_dz, vel_dx, vel_dy, vel_dz;
    q16_t near_density_first, near_density_second, far_density_first, far_density_second;
    logic out_valid;
    logic out_ready;
    q16_t force_x, force_y, force_z;

    pair_force_board board;
    longint cycles = 0;
    bit stall_enable;

    double_density_pair_force_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_dx(pos_dx), .pos_dy(pos_dy), .pos_dz(pos_dz),
        .vel_dx(vel_dx), .vel_dy(vel_dy), .vel_dz(vel_dz),
        .near_density_first(near_density_first), .near_density_second(near_density_second),
        .far_density_first(far_density_first), .far_density_second(far_density_second),
        .out_valid(out_valid), .out_ready(out_ready),
        .force_x(force_x), .force_y(force_y), .force_z(force_z)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic q16_t rand_word();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return 32'(int'($urandom_range(0, 8)) - 4);
            4, 5: return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == RegLengthScale)
        begin
            board.length_scale = val[30:0];
        end
        else if (idx == RegPressureGain)
        begin
            board.pressure_gain = val;
        end
        else if (idx == RegDampingGain)
        begin
            board.damping_gain = val;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // valid stays high between back-to-back beats; callers drop it before idling
    task automatic send_pair(input q16_t f[10]);
        int gap;
        q16_t rp[3];
        q16_t rv[3];
        @(negedge clk);
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pos_dx <= f[0]; pos_dy <= f[1]; pos_dz <= f[2];
        vel_dx <= f[3]; vel_dy <= f[4]; vel_dz <= f[5];
        near_density_first <= f[6]; near_density_second <= f[7];
        far_density_first <= f[8]; far_density_second <= f[9];
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        rp = '{f[0], f[1], f[2]};
        rv = '{f[3], f[4], f[5]};
        board.note_pair(rp, rv, f[6], f[7], f[8], f[9]);
    endtask

    task automatic send_random(input int count);
        q16_t f[10];
        for (int k = 0; k < count; k++)
        begin
            for (int j = 0; j < 10; j++)
            begin
                f[j] = rand_word();
            end
            send_pair(f);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.fx_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (Latency + 20) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            board.check_force(force_x, force_y, force_z);
        end
        if (cycles > CycleLimit)
        begin
            $display("double_density_pair_force_core test failed");
            $finish;
        end
    end

    initial
    begin
        int g;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            g = stall_enable ? gap_len() : 0;
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    initial
    begin
        q16_t f[10];
        board = new();
        stall_enable = 1'b1;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        {pos_dx, pos_dy, pos_dz, vel_dx, vel_dy, vel_dz} = '0;
        {near_density_first, near_density_second} = '0;
        {far_density_first, far_density_second} = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, then extremes and zero separation, then extreme register settings
        f = '{default: 32'sd0};
        send_pair(f);
        f = '{32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
              32'sd131072, 32'sd65536, 32'sd65536, 32'sd0};
        send_pair(f);
        f = '{default: 32'sh7fffffff};
        send_pair(f);
        f = '{default: 32'sh80000000};
        send_pair(f);
        f = '{32'sd1000, -32'sd2000, 32'sd3000, 32'sd5, -32'sd7, 32'sd9,
              32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000};
        send_pair(f);
        f = '{32'sd0, 32'sd0, 32'sd0, 32'sd65536, -32'sd65536, 32'sh7fffffff,
              32'sd100, 32'sd100, 32'sd100, 32'sd100};
        send_pair(f);
        drain();
        write_reg(RegDampingGain, 32'sd65536);
        write_reg(RegLengthScale, 32'd0);
        send_pair(f);
        f = '{32'sd40000, 32'sd30000, -32'sd20000, 32'sd65536, 32'sd0, -32'sd65536,
              32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536};
        send_pair(f);
        drain();
        write_reg(RegLengthScale, 32'h7fffffff);
        write_reg(RegPressureGain, 32'h80000000);
        write_reg(RegDampingGain, 32'h7fffffff);
        send_pair(f);
        f = '{default: 32'sh7fffffff};
        send_pair(f);
        f = '{default: 32'sh80000000};
        send_pair(f);
        drain();
        write_reg(RegLengthScale, 32'd65536);
        write_reg(RegPressureGain, 32'h7fffffff);
        write_reg(RegDampingGain, 32'h80000000);
        send_random(12);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(RegLengthScale, (ph == 5) ? 32'h7fffffff : $urandom_range(1, 1 << 22));
            write_reg(RegPressureGain, rand_word());
            write_reg(RegDampingGain, rand_word());
            stall_enable = (ph != 2);
            send_random(140);
            // hold the sender until the pipe is empty
            @(negedge clk);
            in_valid <= 1'b0;
            while (board.fx_q.size() != 0)
            begin
                @(posedge clk);
            end
            send_random(140);
            drain();
        end
        stall_enable = 1'b1;
        write_reg(RegSpare, $urandom);
        send_random(20);
        drain();

        if (board.errors == 0 && board.fx_q.size() == 0)
        begin
            $display("double_density_pair_force_core test passed");
        end
        else
        begin
            $display("double_density_pair_force_core test failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
